>>> rtl/core/nfcd_pkg.sv
package nfcd_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] REPLY_CODE = 8'hD5;
	localparam logic [7:0] MARK_BYTE  = 8'hFF;
	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd255;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_START = 3'd1;
	localparam logic [2:0] ST_BAD_LCS   = 3'd2;
	localparam logic [2:0] ST_NOT_REPLY = 3'd3;
	localparam logic [2:0] ST_ZERO_LEN  = 3'd4;
	localparam logic [2:0] ST_TOO_BIG   = 3'd5;
	localparam logic [2:0] ST_BAD_DCS   = 3'd6;
	localparam logic [2:0] ST_BAD_POST  = 3'd7;

	typedef struct packed {
		logic        is_status;
		logic [7:0]  data_byte;
		logic [2:0]  status_code;
		logic [15:0] payload_length;
	} item_t;

endpackage

>>> rtl/core/nfcd_if.sv
interface nfcd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface nfcd_rep_if;
	logic        valid;
	logic        ready;
	logic        is_status;
	logic [7:0]  data_byte;
	logic [2:0]  status_code;
	logic [15:0] payload_length;

	modport source (output valid, output is_status, output data_byte, output status_code,
		output payload_length, input ready);
	modport sink (input valid, input is_status, input data_byte, input status_code,
		input payload_length, output ready);
endinterface

>>> rtl/core/nfcd_front.sv
module nfcd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  q_space,
	output logic                  push,
	output nfcd_pkg::item_t       push_item
);

	localparam logic [3:0] PH_HUNT   = 4'd0;
	localparam logic [3:0] PH_START1 = 4'd1;
	localparam logic [3:0] PH_START2 = 4'd2;
	localparam logic [3:0] PH_LEN    = 4'd3;
	localparam logic [3:0] PH_LCS    = 4'd4;
	localparam logic [3:0] PH_EXTHI  = 4'd5;
	localparam logic [3:0] PH_EXTLO  = 4'd6;
	localparam logic [3:0] PH_EXTCS  = 4'd7;
	localparam logic [3:0] PH_TFI    = 4'd8;
	localparam logic [3:0] PH_DATA   = 4'd9;
	localparam logic [3:0] PH_DCS    = 4'd10;
	localparam logic [3:0] PH_POST   = 4'd11;

	logic [3:0]  phase_q, phase_d;
	logic [7:0]  length_high_q, length_high_d;
	logic [15:0] frame_length_q, frame_length_d;
	logic [15:0] bytes_left_q, bytes_left_d;
	logic [7:0]  running_sum_q, running_sum_d;
	logic        checksum_ok_q, checksum_ok_d;
	logic [15:0] max_payload_q;
	logic [15:0] payload;
	logic [7:0]  sum8;
	logic        hit;
	logic        push_d;
	nfcd_pkg::item_t item_d;

	assign in_ready = q_space;
	assign hit      = in_valid && q_space;
	assign payload  = frame_length_q - 16'd1;

	always_comb begin
		phase_d        = phase_q;
		length_high_d  = length_high_q;
		frame_length_d = frame_length_q;
		bytes_left_d   = bytes_left_q;
		running_sum_d  = running_sum_q;
		checksum_ok_d  = checksum_ok_q;
		push_d         = 1'b0;
		item_d         = '0;
		sum8           = '0;
		case (phase_q)
			PH_HUNT: begin
				if (in_byte == 8'h00) phase_d = PH_START1;
			end
			PH_START1: begin
				if (in_byte != 8'h00) begin
					push_d = 1'b1;
					item_d.is_status   = 1'b1;
					item_d.status_code = nfcd_pkg::ST_BAD_START;
					phase_d = PH_HUNT;
				end else begin
					phase_d = PH_START2;
				end
			end
			PH_START2: begin
				if (in_byte != nfcd_pkg::MARK_BYTE) begin
					push_d = 1'b1;
					item_d.is_status   = 1'b1;
					item_d.status_code = nfcd_pkg::ST_BAD_START;
					phase_d = PH_HUNT;
				end else begin
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				length_high_d = in_byte;
				phase_d = PH_LCS;
			end
			PH_LCS: begin
				sum8 = length_high_q + in_byte;
				if (length_high_q == nfcd_pkg::MARK_BYTE && in_byte == nfcd_pkg::MARK_BYTE) begin
					phase_d = PH_EXTHI;
				end else if (sum8 != 8'h00) begin
					push_d = 1'b1;
					item_d.is_status   = 1'b1;
					item_d.status_code = nfcd_pkg::ST_BAD_LCS;
					phase_d = PH_HUNT;
				end else begin
					frame_length_d = {8'h00, length_high_q};
					phase_d = PH_TFI;
				end
			end
			PH_EXTHI: begin
				length_high_d = in_byte;
				phase_d = PH_EXTLO;
			end
			PH_EXTLO: begin
				frame_length_d = {length_high_q, in_byte};
				phase_d = PH_EXTCS;
			end
			PH_EXTCS: begin
				sum8 = length_high_q + frame_length_q[7:0] + in_byte;
				if (sum8 != 8'h00) begin
					push_d = 1'b1;
					item_d.is_status   = 1'b1;
					item_d.status_code = nfcd_pkg::ST_BAD_LCS;
					phase_d = PH_HUNT;
				end else begin
					phase_d = PH_TFI;
				end
			end
			PH_TFI: begin
				if (in_byte != nfcd_pkg::REPLY_CODE) begin
					push_d = 1'b1;
					item_d.is_status   = 1'b1;
					item_d.status_code = nfcd_pkg::ST_NOT_REPLY;
					phase_d = PH_HUNT;
				end else if (frame_length_q == 16'd0) begin
					push_d = 1'b1;
					item_d.is_status   = 1'b1;
					item_d.status_code = nfcd_pkg::ST_ZERO_LEN;
					phase_d = PH_HUNT;
				end else if (payload > max_payload_q) begin
					push_d = 1'b1;
					item_d.is_status   = 1'b1;
					item_d.status_code = nfcd_pkg::ST_TOO_BIG;
					phase_d = PH_HUNT;
				end else begin
					bytes_left_d  = payload;
					running_sum_d = nfcd_pkg::REPLY_CODE;
					phase_d = (payload == 16'd0) ? PH_DCS : PH_DATA;
				end
			end
			PH_DATA: begin
				running_sum_d = running_sum_q + in_byte;
				bytes_left_d  = bytes_left_q - 16'd1;
				if (bytes_left_d == 16'd0) phase_d = PH_DCS;
				push_d = 1'b1;
				item_d.data_byte = in_byte;
			end
			PH_DCS: begin
				running_sum_d = running_sum_q + in_byte;
				checksum_ok_d = (running_sum_d == 8'h00);
				phase_d = PH_POST;
			end
			PH_POST: begin
				push_d = 1'b1;
				item_d.is_status      = 1'b1;
				item_d.payload_length = payload;
				if (!checksum_ok_q) item_d.status_code = nfcd_pkg::ST_BAD_DCS;
				else if (in_byte != 8'h00) item_d.status_code = nfcd_pkg::ST_BAD_POST;
				else item_d.status_code = nfcd_pkg::ST_OK;
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	assign push      = hit && push_d;
	assign push_item = item_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			length_high_q  <= '0;
			frame_length_q <= '0;
			bytes_left_q   <= '0;
			running_sum_q  <= '0;
			checksum_ok_q  <= 1'b0;
			max_payload_q  <= nfcd_pkg::MAX_PAYLOAD_RESET;
		end else begin
			if (cfg_we) max_payload_q <= cfg_wdata;
			if (hit) begin
				phase_q        <= phase_d;
				length_high_q  <= length_high_d;
				frame_length_q <= frame_length_d;
				bytes_left_q   <= bytes_left_d;
				running_sum_q  <= running_sum_d;
				checksum_ok_q  <= checksum_ok_d;
			end
		end
	end

endmodule

>>> rtl/core/nfcd_queue.sv
module nfcd_queue #(
	parameter int unsigned DEPTH = nfcd_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  nfcd_pkg::item_t push_item,
	input  logic            pop,
	output logic            head_valid,
	output nfcd_pkg::item_t head_item,
	output logic            space
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	nfcd_pkg::item_t  slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head_valid = (count_q != '0);
	assign head_item  = slot_q[rd_ptr_q];
	assign space      = (count_q != CNT_W'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

>>> rtl/core/nfcd_back.sv
module nfcd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  nfcd_pkg::item_t head_item,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output nfcd_pkg::item_t out_item
);

	logic            out_valid_q;
	nfcd_pkg::item_t out_item_q;

	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= head_valid;
		end
	end

	// payload fields
	always_ff @(posedge clk) begin
		if (pop) begin
			out_item_q.is_status      <= head_item.is_status;
			out_item_q.data_byte      <= head_item.is_status ? 8'h00 : head_item.data_byte;
			out_item_q.status_code    <= head_item.is_status ? head_item.status_code
				: nfcd_pkg::ST_OK;
			out_item_q.payload_length <= head_item.is_status ? head_item.payload_length : 16'd0;
		end
	end

endmodule

>>> rtl/core/nfc_reply_frame_deframer_core.sv
// a result enters the queue when its byte is accepted, then the output register
// throughput: one received byte per cycle, one result per cycle
// input stalls only when the result queue is full; the queue depth sets how long
// the output side can stall before the input side stalls too
// reset: asynchronous, active low; parser back to preamble hunt, queue empty,
// max_payload back to 255
module nfc_reply_frame_deframer_core #(
	parameter int unsigned QUEUE_DEPTH = nfcd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	nfcd_rx_if.sink     rx,
	nfcd_rep_if.source  rep
);

	logic            push, pop, head_valid, space;
	nfcd_pkg::item_t push_item, head_item, out_item;

	nfcd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (rx.valid),
		.in_ready  (rx.ready),
		.in_byte   (rx.rx_byte),
		.q_space   (space),
		.push      (push),
		.push_item (push_item)
	);

	nfcd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item),
		.space      (space)
	);

	nfcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (rep.valid),
		.out_ready  (rep.ready),
		.out_item   (out_item)
	);

	assign rep.is_status      = out_item.is_status;
	assign rep.data_byte      = out_item.data_byte;
	assign rep.status_code    = out_item.status_code;
	assign rep.payload_length = out_item.payload_length;

endmodule

>>> rtl/core/nfcd_checker.sv
module nfcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        is_status,
	input logic [7:0]  data_byte,
	input logic [2:0]  status_code,
	input logic [15:0] payload_length
);

	// a request that is not taken stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("reply request dropped while stalled");

	a_status_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_status |-> data_byte == 8'h00)
		else $error("status request carries a data byte");

	a_data_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_status |-> status_code == nfcd_pkg::ST_OK && payload_length == 16'd0)
		else $error("payload request carries status fields");

	a_early_err_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_status && (status_code == nfcd_pkg::ST_BAD_START
			|| status_code == nfcd_pkg::ST_BAD_LCS || status_code == nfcd_pkg::ST_NOT_REPLY
			|| status_code == nfcd_pkg::ST_ZERO_LEN || status_code == nfcd_pkg::ST_TOO_BIG)
		|-> payload_length == 16'd0)
		else $error("header error reports a payload length");

endmodule

bind nfc_reply_frame_deframer_core nfcd_checker u_nfcd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (rep.valid),
	.out_ready      (rep.ready),
	.is_status      (rep.is_status),
	.data_byte      (rep.data_byte),
	.status_code    (rep.status_code),
	.payload_length (rep.payload_length)
);
